// ----- hdl/assert_macros.svh -----
// Assertion helpers for the checker file.
// Each macro builds one labeled concurrent assertion with a
// reset that disables the check.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ----- hdl/u2l_pkg.sv -----
// ---------------------------------------------------------------------------
// u2l_pkg
// Types and constants shared by the UTF-8 to Latin-1 converter.
// ---------------------------------------------------------------------------
package u2l_pkg;

  localparam int CFG_IDX_W = 1;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FALLBACK_CHAR = 1'b0,
    CFG_MIN_CODE      = 1'b1
  } cfg_idx_t;

  localparam logic [7:0] FALLBACK_RESET = 8'd63;
  localparam logic [7:0] MIN_CODE_RESET = 8'd32;

  // Result queue geometry.
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  typedef struct packed {
    logic [7:0] out_char;
    logic       run_last;
  } result_t;

  typedef struct packed {
    logic [7:0] fallback_char;
    logic [7:0] min_code;
  } cfg_t;

  // Held bytes of an unfinished sequence.
  typedef struct packed {
    logic [1:0]      count;
    logic [1:0]      seq_len;
    logic [2:0][7:0] data;
  } pend_t;

  // Decoder verdict for one accepted byte.
  typedef struct packed {
    logic [1:0]       n_res;
    result_t [1:0]    res;
    logic [1:0]       count_next;
    logic [1:0]       seq_next;
    logic             wr_en;
    logic [1:0]       wr_idx;
  } dec_t;

endpackage

// ----- hdl/u2l_in_if.sv -----
// ---------------------------------------------------------------------------
// u2l_in_if
// Byte stream channel: one raw UTF-8 byte and an end-of-string flag.
// ---------------------------------------------------------------------------
interface u2l_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       is_last;

  modport source (output valid, output in_byte, output is_last, input ready);
  modport sink (input valid, input in_byte, input is_last, output ready);
endinterface

// ----- hdl/u2l_out_if.sv -----
// ---------------------------------------------------------------------------
// u2l_out_if
// Character channel: one converted font byte and a run-end flag.
// ---------------------------------------------------------------------------
interface u2l_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       run_last;

  modport source (output valid, output out_char, output run_last, input ready);
  modport sink (input valid, input out_char, input run_last, output ready);
endinterface

// ----- hdl/u2l_cfg_if.sv -----
// ---------------------------------------------------------------------------
// u2l_cfg_if
// Configuration write channel: register index and write data.
// ---------------------------------------------------------------------------
interface u2l_cfg_if;
  import u2l_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [7:0]           data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ----- hdl/u2l_decode.sv -----
// ---------------------------------------------------------------------------
// u2l_decode
// Decodes one byte against the held sequence state; gives up to two results.
// ---------------------------------------------------------------------------
module u2l_decode import u2l_pkg::*; (
  input  logic [7:0] in_byte,
  input  logic       is_last,
  input  pend_t      pend,
  input  cfg_t       cfg,
  output dec_t       dec
);

  logic       complete;
  logic [7:0] x;
  logic [1:0] fc;
  logic [1:0] fx;
  logic [1:0] fy;

  function automatic logic [1:0] followers_of(input logic [7:0] c);
    logic [1:0] f;
    f = 2'd0;
    if (c[7:5] == 3'b110) f = 2'd1;
    else if (c[7:4] == 4'b1110) f = 2'd2;
    else if (c[7:3] == 5'b11110) f = 2'd3;
    return f;
  endfunction

  function automatic logic [7:0] map_code(input logic [15:0] cp, input cfg_t k);
    logic [7:0] r;
    r = k.fallback_char;
    if (cp >= {8'd0, k.min_code} && cp <= 16'h00FF) r = cp[7:0];
    return r;
  endfunction

  function automatic logic [7:0] single(input logic [7:0] c, input cfg_t k);
    return c[7] ? k.fallback_char : c;
  endfunction

  function automatic logic [7:0] seq2(input logic [7:0] b0, input logic [7:0] b1,
                                      input cfg_t k);
    return map_code({5'd0, b0[4:0], b1[5:0]}, k);
  endfunction

  function automatic logic [7:0] seq3(input logic [7:0] b0, input logic [7:0] b1,
                                      input logic [7:0] b2, input cfg_t k);
    return map_code({b0[3:0], b1[5:0], b2[5:0]}, k);
  endfunction

  assign complete = (pend.count != 2'd0) && (pend.count == pend.seq_len);
  assign x        = pend.data[1];
  assign fc       = followers_of(in_byte);
  assign fx       = followers_of(x);
  assign fy       = fc;

  always_comb begin
    dec            = '0;
    dec.count_next = pend.count;
    dec.seq_next   = pend.seq_len;
    if (complete) begin
      // The current byte finishes the held sequence.
      dec.n_res          = 2'd1;
      dec.res[0].run_last = 1'b1;
      dec.count_next     = 2'd0;
      dec.seq_next       = 2'd0;
      case (pend.seq_len)
        2'd1:    dec.res[0].out_char = seq2(pend.data[0], in_byte, cfg);
        2'd2:    dec.res[0].out_char = seq3(pend.data[0], pend.data[1], in_byte, cfg);
        default: dec.res[0].out_char = cfg.fallback_char;
      endcase
    end else if (!is_last) begin
      if (pend.count != 2'd0) begin
        dec.wr_en      = 1'b1;
        dec.wr_idx     = pend.count;
        dec.count_next = pend.count + 2'd1;
      end else if (fc != 2'd0) begin
        dec.wr_en      = 1'b1;
        dec.wr_idx     = 2'd0;
        dec.count_next = 2'd1;
        dec.seq_next   = fc;
      end else begin
        dec.n_res           = 2'd1;
        dec.res[0].out_char = single(in_byte, cfg);
        dec.res[0].run_last = 1'b1;
      end
    end else begin
      // End of string: the held lead byte is dropped and the rest decoded again.
      dec.count_next = 2'd0;
      dec.seq_next   = 2'd0;
      if (pend.count != 2'd2) begin
        if (fc == 2'd0) begin
          dec.n_res           = 2'd1;
          dec.res[0].out_char = single(in_byte, cfg);
          dec.res[0].run_last = 1'b1;
        end
      end else if (fx == 2'd0) begin
        dec.res[0].out_char = single(x, cfg);
        if (fy == 2'd0) begin
          dec.n_res           = 2'd2;
          dec.res[1].out_char = single(in_byte, cfg);
          dec.res[1].run_last = 1'b1;
        end else begin
          dec.n_res           = 2'd1;
          dec.res[0].run_last = 1'b1;
        end
      end else if (fx == 2'd1) begin
        dec.n_res           = 2'd1;
        dec.res[0].out_char = seq2(x, in_byte, cfg);
        dec.res[0].run_last = 1'b1;
      end else if (fy == 2'd0) begin
        dec.n_res           = 2'd1;
        dec.res[0].out_char = single(in_byte, cfg);
        dec.res[0].run_last = 1'b1;
      end
    end
  end

endmodule

// ----- hdl/u2l_results.sv -----
// ---------------------------------------------------------------------------
// u2l_results
// Small result queue: takes up to two results a cycle, delivers one.
// ---------------------------------------------------------------------------
module u2l_results import u2l_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  input  logic [1:0]     push_n,
  input  result_t [1:0]  push_res,
  output logic           room,
  u2l_out_if.source      chars
);

  result_t            mem [FIFO_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic [PTR_W-1:0]   wr_ptr_1;
  logic               pop;

  assign pop      = chars.valid && chars.ready;
  assign wr_ptr_1 = wr_ptr + PTR_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_W'(push_n);
      rd_ptr <= rd_ptr + PTR_W'(pop);
      count  <= count + CNT_W'(push_n) - CNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) mem[wr_ptr] <= push_res[0];
    if (push_n == 2'd2) mem[wr_ptr_1] <= push_res[1];
  end

  // Room for a worst-case pair of results from the next byte.
  assign room           = count <= CNT_W'(FIFO_DEPTH - 2);
  assign chars.valid    = count != '0;
  assign chars.out_char = mem[rd_ptr].out_char;
  assign chars.run_last = mem[rd_ptr].run_last;

endmodule

// ----- hdl/utf8_to_latin1_converter.sv -----
// ---------------------------------------------------------------------------
// utf8_to_latin1_converter
// Converts a UTF-8 byte stream into single-byte font characters.
// ---------------------------------------------------------------------------
//
//   Channel  Dir  Payload              Request
//   bytes    in   in_byte, is_last     one raw UTF-8 byte of a string
//   chars    out  out_char, run_last   one font character
//   cfg      in   index, data          one register write
//
// One byte is accepted per cycle; its zero to two characters are in the
// result queue at the next edge, and the queue delivers one per ready cycle.
// The decode is a single combinational pass from the held sequence state
// and the incoming byte into the queue, so the rate is set by the queue's
// single read port: a string of ASCII bytes streams at one per cycle.
// Reset (synchronous, active high) empties the queue and the held sequence
// and restores the fallback character to '?' and the minimum code to 0x20.
// When the queue cannot take a further pair of results, bytes.ready drops.
//
module utf8_to_latin1_converter import u2l_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  u2l_in_if.sink   bytes,
  u2l_out_if.source chars,
  u2l_cfg_if.sink  cfg
);

  cfg_t       cfg_regs;
  pend_t      pend;
  dec_t       dec;
  logic       room;
  logic       accept;
  logic [1:0] push_n;

  // Configuration is always taken; the user must write only while the block is idle (not enforced here).
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.fallback_char <= FALLBACK_RESET;
      cfg_regs.min_code      <= MIN_CODE_RESET;
    end else if (cfg.valid) begin
      unique case (cfg_idx_t'(cfg.index))
        CFG_FALLBACK_CHAR: cfg_regs.fallback_char <= cfg.data;
        CFG_MIN_CODE:      cfg_regs.min_code      <= cfg.data;
        default: ;
      endcase
    end
  end

  assign bytes.ready = room;
  assign accept      = bytes.valid && bytes.ready;

  // Count and expected length of the sequence being collected. The held
  // bytes themselves carry no reset; they are read only once written.
  always_ff @(posedge clk) begin
    if (rst) begin
      pend.count   <= 2'd0;
      pend.seq_len <= 2'd0;
    end else if (accept) begin
      pend.count   <= dec.count_next;
      pend.seq_len <= dec.seq_next;
    end
    if (accept && dec.wr_en) begin
      pend.data[dec.wr_idx] <= bytes.in_byte;
    end
  end

  u2l_decode u_decode (
    .in_byte (bytes.in_byte),
    .is_last (bytes.is_last),
    .pend    (pend),
    .cfg     (cfg_regs),
    .dec     (dec)
  );

  assign push_n = accept ? dec.n_res : 2'd0;

  u2l_results u_results (
    .clk      (clk),
    .rst      (rst),
    .push_n   (push_n),
    .push_res (dec.res),
    .room     (room),
    .chars    (chars)
  );

endmodule

// ----- hdl/u2l_checker.sv -----
// ---------------------------------------------------------------------------
// u2l_checker
// Port-level checks for the converter, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module u2l_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_char,
  input logic       run_last
);

  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid)
  `ASSERT_NEXT(a_out_stable, clk, rst, out_valid && !out_ready, $stable(out_char) && $stable(run_last))
  `ASSERT_IMPLIES(a_reset_empty, clk, rst, $past(rst), !out_valid)
  `ASSERT_IMPLIES(a_stall_backlog, clk, rst, in_valid && !in_ready, out_valid)

endmodule

bind utf8_to_latin1_converter u2l_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (bytes.valid),
  .in_ready  (bytes.ready),
  .out_valid (chars.valid),
  .out_ready (chars.ready),
  .out_char  (chars.out_char),
  .run_last  (chars.run_last)
);
